>>> sv/lshbr_pkg.sv
package lshbr_pkg;

    // block geometry
    localparam int TABLES        = 8;
    localparam int MAX_ROW_BITS  = 8;
    localparam int MAX_RESERVOIR = 16;
    localparam int RAND_SIZE     = 1024;

    // field widths
    localparam int TBL_W   = 3;
    localparam int HASH_W  = 32;
    localparam int LBL_W   = 32;
    localparam int RIDX_W  = 10;
    localparam int RVAL_W  = 10;
    localparam int CNT_W   = 32;
    localparam int SLOT_W  = 4;
    localparam int RIU_W   = 5;
    localparam int RB_W    = 4;

    // derived address widths and depths
    localparam int TSEL_W   = $clog2(TABLES);
    localparam int CNT_AW   = TSEL_W + MAX_ROW_BITS;
    localparam int CNT_D    = TABLES * (2 ** MAX_ROW_BITS);
    localparam int RES_AW   = $clog2(MAX_RESERVOIR);
    localparam int LBL_AW   = CNT_AW + RES_AW;
    localparam int LBL_D    = CNT_D * MAX_RESERVOIR;
    localparam int RAND_AW  = $clog2(RAND_SIZE);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVOIR_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BITS         = 1'd1;

    // item kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    localparam logic [RIU_W-1:0] RIU_RESET = 5'd16;
    localparam logic [RB_W-1:0]  RB_RESET  = 4'd8;

    typedef logic [CNT_W-1:0] t_count;

endpackage

>>> sv/lsh_bucket_reservoir_insert.sv
// channel   dir  handshake                signals
// -------   ---  -----------------------  -----------------------------------------------
// item      in   start && !busy           i_kind i_table_number i_hash_value i_label
//                                         i_rand_index i_rand_value
// result    out  o_strobe, one cycle      o_stored o_slot o_offered_before
// config    in   i_cfg_valid/o_cfg_ready  i_cfg_index i_cfg_data
//
// an item reads its bucket counter on accept; ST_CNT writes the counter back and
// reads the random slot table at the old count; ST_RES picks the slot and writes
// the label; the strobe comes in the next cycle while an item can already be accepted.
// after reset a clearing pass zeroes the 2048 bucket counters, one a cycle,
// with busy high until it ends; config writes are taken throughout.
// results cannot be stalled: each is shown for exactly one cycle.
module lsh_bucket_reservoir_insert (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_kind,
    input  logic [lshbr_pkg::TBL_W-1:0]         i_table_number,
    input  logic [lshbr_pkg::HASH_W-1:0]        i_hash_value,
    input  logic [lshbr_pkg::LBL_W-1:0]         i_label,
    input  logic [lshbr_pkg::RIDX_W-1:0]        i_rand_index,
    input  logic [lshbr_pkg::RVAL_W-1:0]        i_rand_value,
    output logic                                o_strobe,
    output logic                                o_stored,
    output logic [lshbr_pkg::SLOT_W-1:0]        o_slot,
    output logic [lshbr_pkg::CNT_W-1:0]         o_offered_before,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lshbr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lshbr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_CNT   = 2'd2;
    localparam logic [1:0] ST_RES   = 2'd3;

    localparam int TSEL_W  = lshbr_pkg::TSEL_W;
    localparam int ROW_W   = lshbr_pkg::MAX_ROW_BITS;
    localparam int CNT_AW  = lshbr_pkg::CNT_AW;
    localparam int RES_AW  = lshbr_pkg::RES_AW;
    localparam int LBL_AW  = lshbr_pkg::LBL_AW;
    localparam int RAND_AW = lshbr_pkg::RAND_AW;
    localparam int RIU_W   = lshbr_pkg::RIU_W;
    localparam int RB_W    = lshbr_pkg::RB_W;
    localparam int RVAL_W  = lshbr_pkg::RVAL_W;
    localparam int SLOT_W  = lshbr_pkg::SLOT_W;

    // memories
    lshbr_pkg::t_count               r_cnt_mem  [lshbr_pkg::CNT_D];
    logic [lshbr_pkg::LBL_W-1:0]     r_lbl_mem  [lshbr_pkg::LBL_D];
    logic [RVAL_W-1:0]               r_rand_mem [lshbr_pkg::RAND_SIZE];

    logic [1:0]               r_state, n_state;
    logic [CNT_AW-1:0]        r_clr_addr;
    logic [RIU_W-1:0]         r_riu;
    logic [RB_W-1:0]          r_rb;

    // item context
    logic                     r_ins;
    logic [CNT_AW-1:0]        r_addr;
    logic [lshbr_pkg::LBL_W-1:0] r_label;
    lshbr_pkg::t_count        r_cnt_q;
    lshbr_pkg::t_count        r_old;
    logic                     r_direct;
    logic [RVAL_W-1:0]        r_rand_q;

    logic                     r_strobe;
    logic                     r_stored;
    logic [SLOT_W-1:0]        r_slot;
    lshbr_pkg::t_count        r_offered;

    logic                     w_accept;
    logic                     w_ins;
    logic [RB_W-1:0]          w_rb;
    logic [RIU_W-1:0]         w_limit;
    logic [ROW_W-1:0]         w_mask;
    logic [ROW_W-1:0]         w_row;
    logic [CNT_AW-1:0]        w_addr;
    lshbr_pkg::t_count        w_next_cnt;
    logic [RVAL_W-1:0]        w_slot_full;
    logic                     w_store;
    logic                     w_cnt_we;
    logic [CNT_AW-1:0]        w_cnt_waddr;
    lshbr_pkg::t_count        w_cnt_wdata;

    assign busy        = (r_state == ST_CLEAR) || (r_state == ST_CNT);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    // clamp config to the built geometry
    assign w_rb    = (r_rb > RB_W'(ROW_W)) ? RB_W'(ROW_W) : r_rb;
    assign w_limit = (r_riu > RIU_W'(lshbr_pkg::MAX_RESERVOIR))
                   ? RIU_W'(lshbr_pkg::MAX_RESERVOIR) : r_riu;
    assign w_mask  = ~({ROW_W{1'b1}} << w_rb);
    assign w_row   = i_hash_value[ROW_W-1:0] & w_mask;
    assign w_addr  = {i_table_number[TSEL_W-1:0], w_row};
    assign w_ins   = (i_kind == lshbr_pkg::KIND_INSERT)
                   && ({1'b0, i_table_number} < (lshbr_pkg::TBL_W + 1)'(lshbr_pkg::TABLES));

    assign w_next_cnt = (r_cnt_q == '1) ? r_cnt_q : r_cnt_q + 1'b1;

    // replacement slot choice
    assign w_slot_full = r_direct ? RVAL_W'(r_old[RES_AW-1:0]) : r_rand_q;
    assign w_store     = r_ins && (r_direct || (w_slot_full < RVAL_W'(w_limit)));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CNT;
                end
            end
            ST_CNT: begin
                n_state = ST_RES;
            end
            ST_RES: begin
                n_state = w_accept ? ST_CNT : ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        w_cnt_we    = 1'b0;
        w_cnt_waddr = r_addr;
        w_cnt_wdata = w_next_cnt;
        if (r_state == ST_CLEAR) begin
            w_cnt_we    = 1'b1;
            w_cnt_waddr = r_clr_addr;
            w_cnt_wdata = '0;
        end else if (r_state == ST_CNT) begin
            w_cnt_we = r_ins;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_riu      <= lshbr_pkg::RIU_RESET;
            r_rb       <= lshbr_pkg::RB_RESET;
            r_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_RES);
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    lshbr_pkg::CFG_RESERVOIR_IN_USE: r_riu <= i_cfg_data[RIU_W-1:0];
                    lshbr_pkg::CFG_ROW_BITS:         r_rb  <= i_cfg_data[RB_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // item pipeline
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ins   <= w_ins;
            r_addr  <= w_addr;
            r_label <= i_label;
        end
        if (r_state == ST_CNT) begin
            r_old    <= r_cnt_q;
            r_direct <= r_cnt_q < lshbr_pkg::CNT_W'(w_limit);
        end
        if (r_state == ST_RES) begin
            r_stored  <= w_store;
            r_slot    <= w_store ? w_slot_full[SLOT_W-1:0] : '0;
            r_offered <= r_ins ? r_old : '0;
        end
    end

    // bucket counters
    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            r_cnt_mem[w_cnt_waddr] <= w_cnt_wdata;
        end
        if (w_accept) begin
            r_cnt_q <= r_cnt_mem[w_addr];
        end
    end

    // random slot table
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_kind == lshbr_pkg::KIND_LOAD)) begin
            r_rand_mem[i_rand_index[RAND_AW-1:0]] <= i_rand_value;
        end
        if (r_state == ST_CNT) begin
            r_rand_q <= r_rand_mem[r_cnt_q[RAND_AW-1:0]];
        end
    end

    // reservoir labels
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_RES) && w_store) begin
            r_lbl_mem[LBL_AW'({r_addr, w_slot_full[RES_AW-1:0]})] <= r_label;
        end
    end

    assign o_strobe         = r_strobe;
    assign o_stored         = r_stored;
    assign o_slot           = r_slot;
    assign o_offered_before = r_offered;

    a_strobe_after_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) == ST_RES)
        else $error("result strobe without a finished item");

    a_accept_to_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == ST_CNT)
        else $error("accepted item did not start counter update");

    a_cnt_to_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CNT |=> r_state == ST_RES && o_cfg_ready)
        else $error("counter update not followed by slot resolve");

    a_unstored_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_stored |-> o_slot == '0)
        else $error("slot reported for a dropped label");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR |-> !w_accept && !o_strobe)
        else $error("item activity during counter clear");

endmodule

>>> test/tb_lsh_bucket_reservoir_insert.sv
`timescale 1ns / 1ps

typedef struct packed {
    logic                         kind;
    logic [lshbr_pkg::TBL_W-1:0]  tbl;
    logic [lshbr_pkg::HASH_W-1:0] hash;
    logic [lshbr_pkg::LBL_W-1:0]  label;
    logic [lshbr_pkg::RIDX_W-1:0] rand_index;
    logic [lshbr_pkg::RVAL_W-1:0] rand_value;
} t_lsh_item;

typedef struct packed {
    logic                         stored;
    logic [lshbr_pkg::SLOT_W-1:0] slot;
    lshbr_pkg::t_count            offered;
} t_insert_outcome;

class reservoir_scoreboard;
    lshbr_pkg::t_count            offer_count [lshbr_pkg::CNT_D];
    logic [lshbr_pkg::RVAL_W-1:0] replace_slot [lshbr_pkg::RAND_SIZE];
    bit                           replace_loaded [lshbr_pkg::RAND_SIZE];
    logic [lshbr_pkg::RIU_W-1:0]  slots_in_use;
    logic [lshbr_pkg::RB_W-1:0]   row_bits;
    t_insert_outcome              expected_outcomes [$];
    int                           mismatches;

    function new();
        foreach (offer_count[i]) offer_count[i] = '0;
        foreach (replace_loaded[i]) replace_loaded[i] = 1'b0;
        slots_in_use = lshbr_pkg::RIU_RESET;
        row_bits     = lshbr_pkg::RB_RESET;
        mismatches   = 0;
    endfunction

    function void write_reg(logic [lshbr_pkg::CFG_IDX_W-1:0] idx,
                            logic [lshbr_pkg::CFG_DATA_W-1:0] data);
        if (idx == lshbr_pkg::CFG_RESERVOIR_IN_USE)
            slots_in_use = data[lshbr_pkg::RIU_W-1:0];
        else if (idx == lshbr_pkg::CFG_ROW_BITS)
            row_bits = data[lshbr_pkg::RB_W-1:0];
    endfunction

    function int unsigned slot_limit();
        return (slots_in_use > lshbr_pkg::MAX_RESERVOIR) ? lshbr_pkg::MAX_RESERVOIR
                                                         : slots_in_use;
    endfunction

    function int unsigned bucket_of(logic [lshbr_pkg::TBL_W-1:0] tbl,
                                    logic [lshbr_pkg::HASH_W-1:0] hash);
        int unsigned rb;
        rb = (row_bits > lshbr_pkg::MAX_ROW_BITS) ? lshbr_pkg::MAX_ROW_BITS : row_bits;
        return tbl * (2 ** lshbr_pkg::MAX_ROW_BITS) + (hash & ((32'd1 << rb) - 32'd1));
    endfunction

    // random table entry that this insert would read but that was never loaded
    function int missing_rand_entry(logic [lshbr_pkg::TBL_W-1:0] tbl,
                                    logic [lshbr_pkg::HASH_W-1:0] hash);
        lshbr_pkg::t_count old;
        int                idx;
        old = offer_count[bucket_of(tbl, hash)];
        idx = int'(old % lshbr_pkg::RAND_SIZE);
        if (old >= slot_limit() && !replace_loaded[idx])
            return idx;
        return -1;
    endfunction

    function void log_item(t_lsh_item it);
        t_insert_outcome              r;
        int unsigned                  bkt;
        int unsigned                  lim;
        lshbr_pkg::t_count            old;
        logic [lshbr_pkg::RVAL_W-1:0] s;
        r = '0;
        if (it.kind == lshbr_pkg::KIND_LOAD) begin
            replace_slot[it.rand_index]   = it.rand_value;
            replace_loaded[it.rand_index] = 1'b1;
        end else begin
            bkt = bucket_of(it.tbl, it.hash);
            lim = slot_limit();
            old = offer_count[bkt];
            if (old != '1)
                offer_count[bkt] = old + 1'b1;
            if (old < lim) begin
                r.stored = 1'b1;
                r.slot   = old[lshbr_pkg::SLOT_W-1:0];
            end else begin
                s = replace_slot[old % lshbr_pkg::RAND_SIZE];
                if (s < lim) begin
                    r.stored = 1'b1;
                    r.slot   = s[lshbr_pkg::SLOT_W-1:0];
                end
            end
            r.offered = old;
        end
        expected_outcomes.push_back(r);
    endfunction

    function void check_outcome(logic stored, logic [lshbr_pkg::SLOT_W-1:0] slot,
                                lshbr_pkg::t_count offered);
        t_insert_outcome e;
        if (expected_outcomes.size() == 0) begin
            $display("%0t: result with none expected: stored %0d slot %0d offered %0d",
                     $time, stored, slot, offered);
            mismatches++;
            return;
        end
        e = expected_outcomes.pop_front();
        if (stored !== e.stored) begin
            $display("%0t: stored expected %0d actual %0d", $time, e.stored, stored);
            mismatches++;
        end
        if (slot !== e.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, e.slot, slot);
            mismatches++;
        end
        if (offered !== e.offered) begin
            $display("%0t: offered_before expected %0d actual %0d", $time, e.offered, offered);
            mismatches++;
        end
    endfunction

    function int outstanding();
        return expected_outcomes.size();
    endfunction
endclass

module tb_lsh_bucket_reservoir_insert;

    localparam int STALL_LIMIT = 6000;   // covers the counter clearing pass after reset
    localparam int PHASES      = 7;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             start;
    logic                             busy;
    logic                             i_kind;
    logic [lshbr_pkg::TBL_W-1:0]      i_table_number;
    logic [lshbr_pkg::HASH_W-1:0]     i_hash_value;
    logic [lshbr_pkg::LBL_W-1:0]      i_label;
    logic [lshbr_pkg::RIDX_W-1:0]     i_rand_index;
    logic [lshbr_pkg::RVAL_W-1:0]     i_rand_value;
    logic                             o_strobe;
    logic                             o_stored;
    logic [lshbr_pkg::SLOT_W-1:0]     o_slot;
    logic [lshbr_pkg::CNT_W-1:0]      o_offered_before;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [lshbr_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [lshbr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    reservoir_scoreboard              sb;
    bit                               calm;
    int unsigned                      stall_cycles;
    logic [lshbr_pkg::RIU_W-1:0]      phase_in_use [PHASES];
    logic [lshbr_pkg::CFG_DATA_W-1:0] phase_row_bits [PHASES];

    lsh_bucket_reservoir_insert dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.log_item('{i_kind, i_table_number, i_hash_value, i_label,
                              i_rand_index, i_rand_value});
            if (o_strobe)
                sb.check_outcome(o_stored, o_slot, o_offered_before);
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
        end
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [lshbr_pkg::RVAL_W-1:0] pick_slot_value();
        if ($urandom_range(0, 99) < 70)
            return lshbr_pkg::RVAL_W'($urandom_range(0, 20));
        return lshbr_pkg::RVAL_W'($urandom_range(0, lshbr_pkg::RAND_SIZE - 1));
    endfunction

    function automatic t_lsh_item load_item(int unsigned idx, int unsigned val);
        t_lsh_item it;
        it = '0;
        it.kind       = lshbr_pkg::KIND_LOAD;
        it.rand_index = lshbr_pkg::RIDX_W'(idx);
        it.rand_value = lshbr_pkg::RVAL_W'(val);
        return it;
    endfunction

    function automatic t_lsh_item insert_item(int unsigned tbl,
                                              logic [lshbr_pkg::HASH_W-1:0] hash,
                                              logic [lshbr_pkg::LBL_W-1:0] label);
        t_lsh_item it;
        it = '0;
        it.kind  = lshbr_pkg::KIND_INSERT;
        it.tbl   = lshbr_pkg::TBL_W'(tbl);
        it.hash  = hash;
        it.label = label;
        return it;
    endfunction

    // mostly inserts packed onto a few buckets so reservoirs overflow
    function automatic t_lsh_item random_item();
        t_lsh_item it;
        it.kind       = ($urandom_range(0, 99) < 15) ? lshbr_pkg::KIND_LOAD
                                                     : lshbr_pkg::KIND_INSERT;
        it.tbl        = ($urandom_range(0, 99) < 60)
                      ? lshbr_pkg::TBL_W'($urandom_range(0, 1))
                      : lshbr_pkg::TBL_W'($urandom_range(0, lshbr_pkg::TABLES - 1));
        it.hash       = $urandom;
        if ($urandom_range(0, 99) < 70)
            it.hash[7:0] = 8'($urandom_range(0, 3));
        it.label      = $urandom;
        it.rand_index = lshbr_pkg::RIDX_W'($urandom_range(0, lshbr_pkg::RAND_SIZE - 1));
        it.rand_value = pick_slot_value();
        return it;
    endfunction

    task automatic take_gaps();
        while (!calm && $urandom_range(0, 99) < 11) begin
            @(negedge i_clk);
            start          = 1'b0;
            i_kind         = 1'($urandom_range(0, 1));
            i_table_number = lshbr_pkg::TBL_W'($urandom_range(0, lshbr_pkg::TABLES - 1));
            i_hash_value   = $urandom;
            i_label        = $urandom;
        end
    endtask

    // called at a falling edge; returns at the rising edge that takes the item
    task automatic present(input t_lsh_item it);
        i_kind         = it.kind;
        i_table_number = it.tbl;
        i_hash_value   = it.hash;
        i_label        = it.label;
        i_rand_index   = it.rand_index;
        i_rand_value   = it.rand_value;
        start          = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_item(input t_lsh_item it);
        int miss;
        take_gaps();
        @(negedge i_clk);
        if (it.kind == lshbr_pkg::KIND_INSERT) begin
            // load the replacement entry first if this insert would read it unwritten
            miss = sb.missing_rand_entry(it.tbl, it.hash);
            if (miss >= 0) begin
                present(load_item(miss, pick_slot_value()));
                @(negedge i_clk);
            end
        end
        present(it);
    endtask

    task automatic settle();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [lshbr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lshbr_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        int p;
        sb             = new();
        calm           = 1'b0;
        stall_cycles   = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_kind         = lshbr_pkg::KIND_INSERT;
        i_table_number = '0;
        i_hash_value   = '0;
        i_label        = '0;
        i_rand_index   = '0;
        i_rand_value   = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = lshbr_pkg::CFG_RESERVOIR_IN_USE;
        i_cfg_data     = '0;
        phase_in_use   = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31, 5'd17, 5'd8};
        phase_row_bits = '{5'd8, 5'd1, 5'd3, 5'd0, 5'd15, 5'd20, 5'd2};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // two slots, two rows: overflow comes quickly
        write_reg(lshbr_pkg::CFG_RESERVOIR_IN_USE, 5'd2);
        write_reg(lshbr_pkg::CFG_ROW_BITS, 5'd1);
        send_item(load_item(0, 1));
        send_item(load_item(lshbr_pkg::RAND_SIZE - 1, lshbr_pkg::RAND_SIZE - 1));
        send_item(load_item(10'h2AA, 10'h155));
        send_item(load_item(10'h155, 10'h2AA));
        send_item(load_item(2, 0));
        send_item(load_item(3, 5));
        repeat (5) send_item(insert_item(0, '0, '0));
        repeat (3) send_item(insert_item(lshbr_pkg::TABLES - 1, '1, '1));

        // no slots and a single row per table
        settle();
        write_reg(lshbr_pkg::CFG_RESERVOIR_IN_USE, 5'd0);
        write_reg(lshbr_pkg::CFG_ROW_BITS, 5'd0);
        repeat (3) send_item(insert_item(3, $urandom, $urandom));

        // both registers past their maximum
        settle();
        write_reg(lshbr_pkg::CFG_RESERVOIR_IN_USE, 5'd31);
        write_reg(lshbr_pkg::CFG_ROW_BITS, 5'd12);
        repeat (3) send_item(insert_item(lshbr_pkg::TABLES - 1, '1, 32'h5A5A_A5A5));

        for (p = 0; p < PHASES; p++) begin
            settle();
            write_reg(lshbr_pkg::CFG_RESERVOIR_IN_USE, phase_in_use[p]);
            write_reg(lshbr_pkg::CFG_ROW_BITS, phase_row_bits[p]);
            calm = (p == 2);
            repeat (90) send_item(random_item());
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
sv/lshbr_pkg.sv
sv/lsh_bucket_reservoir_insert.sv
test/tb_lsh_bucket_reservoir_insert.sv
